>>> rtl/core/esrp_pkg.sv
// shared types and constants for the element status response parser
package esrp_pkg;

    localparam int MAX_NAME_LEN_DEF = 6;
    localparam int NAME_BYTES       = 6;
    localparam int HDR_LEN          = 8;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam int         TAG_BIT    = 7;

    // data header byte offsets
    localparam logic [15:0] DH_COUNT_HI = 16'd2;
    localparam logic [15:0] DH_COUNT_LO = 16'd3;

    // page header byte offsets
    localparam logic [15:0] PH_OFF_TYPE    = 16'd0;
    localparam logic [15:0] PH_OFF_FLAGS   = 16'd1;
    localparam logic [15:0] PH_OFF_DLEN_HI = 16'd2;
    localparam logic [15:0] PH_OFF_DLEN_LO = 16'd3;
    localparam logic [15:0] PH_OFF_CNT_HI  = 16'd5;
    localparam logic [15:0] PH_OFF_CNT_MID = 16'd6;
    localparam logic [15:0] PH_OFF_CNT_LO  = 16'd7;

    // element descriptor byte offsets
    localparam logic [15:0] DO_ADDR_HI = 16'd0;
    localparam logic [15:0] DO_ADDR_LO = 16'd1;
    localparam logic [15:0] DO_STATE   = 16'd2;
    localparam logic [15:0] DO_ASC     = 16'd4;
    localparam logic [15:0] DO_ASCQ    = 16'd5;
    localparam logic [15:0] DO_FLAGS   = 16'd9;
    localparam logic [15:0] DO_SRC_HI  = 16'd10;
    localparam logic [15:0] DO_SRC_LO  = 16'd11;
    localparam logic [15:0] DO_NAME    = 16'd12;

    typedef enum logic [3:0] {
        PH_DATA_HDR = 4'b0001,
        PH_PAGE_HDR = 4'b0010,
        PH_DESC     = 4'b0100,
        PH_DONE     = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        is_element;
        logic [15:0] elem_address;
        logic [7:0]  elem_type;
        logic [7:0]  elem_state;
        logic [7:0]  add_sense_code;
        logic [7:0]  add_sense_qual;
        logic [7:0]  elem_flags;
        logic [15:0] src_elem_addr;
        logic [47:0] name_chars;
        logic [2:0]  name_length;
        logic [15:0] elem_index;
        logic        last_item;
    } t_out;

endpackage

>>> rtl/core/element_status_response_parser_top.sv
// element status response parser: byte-stream parser with a small result queue
//
// Takes one response byte per request and accepts a new byte every cycle while
// the four-entry result queue has room for two results. Each byte updates the
// header/descriptor state; a descriptor's result (and, on the final buffer
// byte, the end marker unless the last element was sent) enters the queue at
// the same edge and can be taken from the next cycle on. A byte produces at most
// two results, so o_ready drops only when the queue holds more than two untaken
// results. After the final buffer byte the parser is back in its reset state.
module element_status_response_parser_top #(
    parameter int MAX_NAME_LEN = esrp_pkg::MAX_NAME_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  esrp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output esrp_pkg::t_out o_data
);
    import esrp_pkg::*;

    localparam int          NameCap  = (MAX_NAME_LEN < NAME_BYTES) ? MAX_NAME_LEN : NAME_BYTES;
    localparam logic [2:0]  NameCapW = 3'(NameCap);
    localparam int          PtrW     = $clog2(FIFO_DEPTH);
    localparam logic [15:0] HdrEnd   = 16'(HDR_LEN - 1);

    // parser state
    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_avail, n_avail;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_dlen, n_dlen;
    logic [23:0] r_left, n_left;
    logic [7:0]  r_ptype, n_ptype;
    logic        r_tags, n_tags;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_state, n_state;
    logic [7:0]  r_asc, n_asc;
    logic [7:0]  r_ascq, n_ascq;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_src, n_src;
    logic [47:0] r_name, n_name;
    logic [2:0]  r_nlen, n_nlen;
    logic        r_nclosed, n_nclosed;

    // descriptor fields with the current byte folded in
    logic [15:0] a_addr;
    logic [7:0]  a_state, a_asc, a_ascq, a_flags;
    logic [15:0] a_src;
    logic [47:0] a_name;
    logic [2:0]  a_nlen;
    logic        a_nclosed;

    logic [7:0]  w_byte;
    logic        w_accept;
    logic [15:0] w_eff, w_pos_inc, w_cnt_inc;
    logic [23:0] w_left_dec;
    logic        w_complete, w_elem_push, w_mark_push;
    t_out        w_elem, w_mark, w_slot0, w_slot1;
    logic [1:0]  w_push;

    // result queue
    t_out            r_fifo [FIFO_DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_count;
    logic            w_pop;
    logic [PtrW-1:0] w_wr1;

    assign w_byte   = i_data.data_byte;
    assign o_ready  = (r_count <= (PtrW+1)'(FIFO_DEPTH - 2));
    assign w_accept = i_valid && o_ready;
    assign o_valid  = (r_count != '0);
    assign o_data   = r_fifo[r_rd];
    assign w_pop    = o_valid && i_ready;
    assign w_wr1    = r_wr + PtrW'(1);

    assign w_eff      = (r_dlen == 16'd0) ? 16'd1 : r_dlen;
    assign w_pos_inc  = r_pos + 16'd1;
    assign w_cnt_inc  = r_cnt + 16'd1;
    assign w_left_dec = (r_left != 24'd0) ? (r_left - 24'd1) : r_left;

    always_comb begin
        a_addr    = r_addr;
        a_state   = r_state;
        a_asc     = r_asc;
        a_ascq    = r_ascq;
        a_flags   = r_flags;
        a_src     = r_src;
        a_name    = r_name;
        a_nlen    = r_nlen;
        a_nclosed = r_nclosed;
        unique case (r_pos)
            DO_ADDR_HI: a_addr[15:8] = w_byte;
            DO_ADDR_LO: a_addr[7:0]  = w_byte;
            DO_STATE:   a_state      = w_byte;
            DO_ASC:     a_asc        = w_byte;
            DO_ASCQ:    a_ascq       = w_byte;
            DO_FLAGS:   a_flags      = w_byte;
            DO_SRC_HI:  a_src[15:8]  = w_byte;
            DO_SRC_LO:  a_src[7:0]   = w_byte;
            default: ;
        endcase
        // volume tag scan ends at space or nul
        if (r_pos >= DO_NAME && r_tags && !r_nclosed) begin
            if (w_byte == CHAR_NUL || w_byte == CHAR_SPACE) begin
                a_nclosed = 1'b1;
            end else if (r_nlen < NameCapW) begin
                for (int i = 0; i < NAME_BYTES; i++) begin
                    if (r_nlen == 3'(i)) begin
                        a_name[8*(NAME_BYTES-1-i) +: 8] = w_byte;
                    end
                end
                a_nlen = r_nlen + 3'd1;
            end
        end
    end

    always_comb begin
        w_elem                = '0;
        w_elem.is_element     = 1'b1;
        w_elem.elem_address   = a_addr;
        w_elem.elem_type      = r_ptype;
        w_elem.elem_state     = a_state;
        w_elem.add_sense_code = a_asc;
        w_elem.add_sense_qual = a_ascq;
        w_elem.elem_flags     = a_flags;
        w_elem.src_elem_addr  = a_src;
        w_elem.name_chars     = a_name;
        w_elem.name_length    = a_nlen;
        w_elem.elem_index     = r_cnt;
        w_elem.last_item      = (w_cnt_inc == r_avail);
        w_mark                = '0;
        w_mark.last_item      = 1'b1;
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_avail   = r_avail;
        n_cnt     = r_cnt;
        n_dlen    = r_dlen;
        n_left    = r_left;
        n_ptype   = r_ptype;
        n_tags    = r_tags;
        n_addr    = r_addr;
        n_state   = r_state;
        n_asc     = r_asc;
        n_ascq    = r_ascq;
        n_flags   = r_flags;
        n_src     = r_src;
        n_name    = r_name;
        n_nlen    = r_nlen;
        n_nclosed = r_nclosed;
        w_complete  = 1'b0;
        w_elem_push = 1'b0;
        w_mark_push = 1'b0;

        unique case (r_phase)
            PH_DATA_HDR: begin
                if (r_pos == DH_COUNT_HI) n_avail[15:8] = w_byte;
                if (r_pos == DH_COUNT_LO) n_avail[7:0]  = w_byte;
                if (r_pos == HdrEnd) begin
                    n_pos   = 16'd0;
                    n_phase = (n_avail != 16'd0) ? PH_PAGE_HDR : PH_DONE;
                end else begin
                    n_pos = w_pos_inc;
                end
            end
            PH_PAGE_HDR: begin
                unique case (r_pos)
                    PH_OFF_TYPE:    n_ptype        = w_byte;
                    PH_OFF_FLAGS:   n_tags         = w_byte[TAG_BIT];
                    PH_OFF_DLEN_HI: n_dlen[15:8]   = w_byte;
                    PH_OFF_DLEN_LO: n_dlen[7:0]    = w_byte;
                    PH_OFF_CNT_HI:  n_left[23:16]  = w_byte;
                    PH_OFF_CNT_MID: n_left[15:8]   = w_byte;
                    PH_OFF_CNT_LO:  n_left[7:0]    = w_byte;
                    default: ;
                endcase
                if (r_pos == HdrEnd) begin
                    n_pos = 16'd0;
                    // empty page goes straight to the next page header
                    if (n_left != 24'd0) begin
                        n_phase   = PH_DESC;
                        n_addr    = '0;
                        n_state   = '0;
                        n_asc     = '0;
                        n_ascq    = '0;
                        n_flags   = '0;
                        n_src     = '0;
                        n_name    = '0;
                        n_nlen    = '0;
                        n_nclosed = 1'b0;
                    end
                end else begin
                    n_pos = w_pos_inc;
                end
            end
            PH_DESC: begin
                n_addr    = a_addr;
                n_state   = a_state;
                n_asc     = a_asc;
                n_ascq    = a_ascq;
                n_flags   = a_flags;
                n_src     = a_src;
                n_name    = a_name;
                n_nlen    = a_nlen;
                n_nclosed = a_nclosed;
                n_left    = w_left_dec;
                if (w_pos_inc >= w_eff) begin
                    w_complete = 1'b1;
                    n_cnt      = w_cnt_inc;
                    n_pos      = 16'd0;
                    n_addr     = '0;
                    n_state    = '0;
                    n_asc      = '0;
                    n_ascq     = '0;
                    n_flags    = '0;
                    n_src      = '0;
                    n_name     = '0;
                    n_nlen     = '0;
                    n_nclosed  = 1'b0;
                    if (w_cnt_inc == r_avail) begin
                        n_phase = PH_DONE;
                    end else if (w_left_dec == 24'd0) begin
                        n_phase = PH_PAGE_HDR;
                    end
                end else begin
                    n_pos = w_pos_inc;
                end
            end
            PH_DONE: ;
            default: n_phase = PH_DATA_HDR;
        endcase

        w_elem_push = w_complete;
        if (i_data.last_byte) begin
            // buffer ends inside a descriptor: flush it with missing bytes as zero
            if (n_phase == PH_DESC && n_pos != 16'd0) begin
                w_elem_push = 1'b1;
                n_cnt       = w_cnt_inc;
            end
            w_mark_push = !(n_avail != 16'd0 && n_cnt == n_avail);
            n_phase   = PH_DATA_HDR;
            n_pos     = '0;
            n_avail   = '0;
            n_cnt     = '0;
            n_dlen    = '0;
            n_left    = '0;
            n_ptype   = '0;
            n_tags    = 1'b0;
            n_addr    = '0;
            n_state   = '0;
            n_asc     = '0;
            n_ascq    = '0;
            n_flags   = '0;
            n_src     = '0;
            n_name    = '0;
            n_nlen    = '0;
            n_nclosed = 1'b0;
        end
    end

    assign w_slot0 = w_elem_push ? w_elem : w_mark;
    assign w_slot1 = w_mark;
    assign w_push  = w_accept ? (2'(w_elem_push) + 2'(w_mark_push)) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DATA_HDR;
            r_pos     <= '0;
            r_avail   <= '0;
            r_cnt     <= '0;
            r_dlen    <= '0;
            r_left    <= '0;
            r_ptype   <= '0;
            r_tags    <= 1'b0;
            r_addr    <= '0;
            r_state   <= '0;
            r_asc     <= '0;
            r_ascq    <= '0;
            r_flags   <= '0;
            r_src     <= '0;
            r_name    <= '0;
            r_nlen    <= '0;
            r_nclosed <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_avail   <= n_avail;
            r_cnt     <= n_cnt;
            r_dlen    <= n_dlen;
            r_left    <= n_left;
            r_ptype   <= n_ptype;
            r_tags    <= n_tags;
            r_addr    <= n_addr;
            r_state   <= n_state;
            r_asc     <= n_asc;
            r_ascq    <= n_ascq;
            r_flags   <= n_flags;
            r_src     <= n_src;
            r_name    <= n_name;
            r_nlen    <= n_nlen;
            r_nclosed <= n_nclosed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PtrW'(w_push);
            r_rd    <= r_rd + PtrW'(w_pop);
            r_count <= r_count + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_fifo[r_wr] <= w_slot0;
        end
        if (w_push == 2'd2) begin
            r_fifo[w_wr1] <= w_slot1;
        end
    end

endmodule

>>> rtl/core/esrp_chk.sv
// port-level checks for the element status response parser, bound to the top level
module esrp_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input esrp_pkg::t_out o_data
);
    import esrp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // the end marker always closes a response and carries nothing else
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.is_element |->
            o_data.last_item && o_data.elem_address == 16'd0 &&
            o_data.name_length == 3'd0 && o_data.elem_index == 16'd0)
        else $error("malformed end marker");

    // name length stays within the field
    a_nlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.name_length <= 3'(NAME_BYTES))
        else $error("name length out of range");

    // no characters without a length
    a_nchr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.name_length == 3'd0 |-> o_data.name_chars == 48'd0)
        else $error("name characters without length");

    // queue is empty and open right after reset
    a_rst: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> o_ready && !o_valid)
        else $error("not idle after reset");

endmodule

bind element_status_response_parser_top esrp_chk u_esrp_chk (.*);
